/* sv/rtmd_pkg.sv */
// ----------------------------------------------------------------------------
// rtmd_pkg
// Shared types, constants and tables of the rigid-transform mean distance block.
// ----------------------------------------------------------------------------
package rtmd_pkg;

    localparam int MAX_POINTS_DEF   = 64;
    localparam int CORDIC_STEPS_DEF = 16;

    localparam int COORD_W    = 27;
    localparam int ANGLE_W    = 25;
    localparam int CFG_IDX_W  = 3;
    localparam int TDATA_W    = 168;
    localparam int OUT_W      = 32;
    localparam int SUM_W      = 40;
    localparam int ENT_W      = 32;
    localparam int OPB_W      = 30;
    localparam int PROD_W     = 62;
    localparam int ACC_W      = 64;
    localparam int SQ_W       = 60;
    localparam int CORD_W     = 34;
    localparam int ZW         = 26;
    localparam int STEP_W     = 6;
    localparam int SQRT_STEPS = 30;
    localparam int DIV_STEPS  = 40;

    localparam logic signed [CORD_W-1:0] CORDIC_GAIN = 34'sd652032874;
    localparam logic signed [ZW-1:0]     DEG90       = 26'sd5898240;
    localparam logic signed [ZW-1:0]     DEG180      = 26'sd11796480;
    localparam logic signed [ENT_W-1:0]  ONE_Q16     = 32'sd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SHIFT_X, REG_SHIFT_Y, REG_SHIFT_Z,
        REG_TILT_X, REG_TILT_Y, REG_TILT_Z
    } cfg_reg_t;

    typedef enum logic [1:0] {MODE_T, MODE_R, MODE_P, MODE_SQ} mode_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CORD_LOAD, ST_CORD_RUN, ST_CORD_STORE, ST_POINT, ST_MAC,
        ST_SQ_MUL, ST_SQ_ADD, ST_SQRT_LOAD, ST_SQRT_RUN, ST_SUM_ADD,
        ST_DIV_LOAD, ST_DIV_RUN, ST_OUT_WAIT
    } state_t;

    typedef struct packed {
        mode_t             mode;
        logic [1:0]        row;
        logic [1:0]        col;
        logic [1:0]        kk;
        logic [1:0]        axis;
        logic [STEP_W-1:0] step;
        logic              capture;
        logic              cord_load;
        logic              cord_step;
        logic              cord_store;
        logic              mul_en;
        logic              acc_add;
        logic              acc_first;
        logic              mac_store;
        logic              sq_add;
        logic              sq_first;
        logic              sqrt_load;
        logic              sqrt_step;
        logic              sum_add;
        logic              div_load;
        logic              div_step;
        logic              out_load;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic last;
        logic out_busy;
    } stat_t;

    // atan(2^-n) in Q16.16 degrees
    function automatic logic [22:0] atan_deg(input logic [4:0] n);
        logic [22:0] r;
        case (n)
            5'd0:    r = 23'd2949120;
            5'd1:    r = 23'd1740967;
            5'd2:    r = 23'd919879;
            5'd3:    r = 23'd466945;
            5'd4:    r = 23'd234379;
            5'd5:    r = 23'd117304;
            5'd6:    r = 23'd58666;
            5'd7:    r = 23'd29335;
            5'd8:    r = 23'd14668;
            5'd9:    r = 23'd7334;
            5'd10:   r = 23'd3667;
            5'd11:   r = 23'd1833;
            5'd12:   r = 23'd917;
            5'd13:   r = 23'd458;
            5'd14:   r = 23'd229;
            5'd15:   r = 23'd115;
            5'd16:   r = 23'd57;
            5'd17:   r = 23'd29;
            5'd18:   r = 23'd14;
            5'd19:   r = 23'd7;
            5'd20:   r = 23'd4;
            5'd21:   r = 23'd2;
            5'd22:   r = 23'd1;
            default: r = 23'd0;
        endcase
        return r;
    endfunction

endpackage

/* sv/rtmd_ctrl.sv */
// ----------------------------------------------------------------------------
// rtmd_ctrl
// Sequencer: rotation build, per-point MAC, square root and final division.
// ----------------------------------------------------------------------------
module rtmd_ctrl #(
    parameter int CORDIC_STEPS = rtmd_pkg::CORDIC_STEPS_DEF
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  rtmd_pkg::stat_t stat,
    output rtmd_pkg::cmd_t  cmd
);
    import rtmd_pkg::*;

    state_t            state_reg, state_next;
    mode_t             mode_reg, mode_next;
    logic [1:0]        row_reg, row_next, col_reg, col_next;
    logic [1:0]        kk_reg, kk_next, axis_reg, axis_next;
    logic [STEP_W-1:0] step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            mode_reg  <= MODE_T;
            row_reg   <= '0;
            col_reg   <= '0;
            kk_reg    <= '0;
            axis_reg  <= '0;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            kk_reg    <= kk_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        mode_next  = mode_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        kk_next    = kk_reg;
        axis_next  = axis_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.mode   = mode_reg;
        cmd.row    = row_reg;
        cmd.col    = col_reg;
        cmd.kk     = kk_reg;
        cmd.axis   = axis_reg;
        cmd.step   = step_reg;
        s_tready   = (state_reg == ST_IDLE);
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.capture = 1'b1;
                    axis_next   = '0;
                    state_next  = stat.cnt_zero ? ST_CORD_LOAD : ST_POINT;
                end
            end
            ST_CORD_LOAD: begin
                cmd.cord_load = 1'b1;
                step_next     = '0;
                state_next    = ST_CORD_RUN;
            end
            ST_CORD_RUN: begin
                cmd.cord_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(CORDIC_STEPS - 1)) state_next = ST_CORD_STORE;
            end
            ST_CORD_STORE: begin
                cmd.cord_store = 1'b1;
                if (axis_reg == 2'd2) begin
                    mode_next  = MODE_T;
                    row_next   = '0;
                    col_next   = '0;
                    kk_next    = '0;
                    state_next = ST_MAC;
                end else begin
                    axis_next  = axis_reg + 1'b1;
                    state_next = ST_CORD_LOAD;
                end
            end
            ST_POINT: begin
                if (stat.cnt_full) begin
                    state_next = stat.last ? ST_DIV_LOAD : ST_IDLE;
                end else begin
                    mode_next  = MODE_P;
                    row_next   = '0;
                    col_next   = '0;
                    kk_next    = '0;
                    state_next = ST_MAC;
                end
            end
            ST_MAC: begin
                cmd.mul_en    = (kk_reg != 2'd3);
                cmd.acc_add   = (kk_reg != 2'd0);
                cmd.acc_first = (kk_reg == 2'd1);
                if (kk_reg == 2'd3) begin
                    cmd.mac_store = 1'b1;
                    kk_next       = '0;
                    if (mode_reg == MODE_P) begin
                        state_next = ST_SQ_MUL;
                    end else if (col_reg == 2'd2) begin
                        col_next = '0;
                        if (row_reg == 2'd2) begin
                            row_next = '0;
                            if (mode_reg == MODE_T) mode_next = MODE_R;
                            else state_next = ST_POINT;
                        end else begin
                            row_next = row_reg + 1'b1;
                        end
                    end else begin
                        col_next = col_reg + 1'b1;
                    end
                end else begin
                    kk_next = kk_reg + 1'b1;
                end
            end
            ST_SQ_MUL: begin
                cmd.mode   = MODE_SQ;
                cmd.mul_en = 1'b1;
                state_next = ST_SQ_ADD;
            end
            ST_SQ_ADD: begin
                cmd.sq_add   = 1'b1;
                cmd.sq_first = (row_reg == 2'd0);
                if (row_reg == 2'd2) begin
                    state_next = ST_SQRT_LOAD;
                end else begin
                    row_next   = row_reg + 1'b1;
                    kk_next    = '0;
                    state_next = ST_MAC;
                end
            end
            ST_SQRT_LOAD: begin
                cmd.sqrt_load = 1'b1;
                step_next     = '0;
                state_next    = ST_SQRT_RUN;
            end
            ST_SQRT_RUN: begin
                cmd.sqrt_step = 1'b1;
                step_next     = step_reg + 1'b1;
                if (step_reg == STEP_W'(SQRT_STEPS - 1)) state_next = ST_SUM_ADD;
            end
            ST_SUM_ADD: begin
                cmd.sum_add = 1'b1;
                state_next  = stat.last ? ST_DIV_LOAD : ST_IDLE;
            end
            ST_DIV_LOAD: begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = ST_DIV_RUN;
            end
            ST_DIV_RUN: begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_W'(DIV_STEPS - 1)) state_next = ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
                if (!stat.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

/* sv/rtmd_datapath.sv */
// ----------------------------------------------------------------------------
// rtmd_datapath
// Registers, CORDIC, shared multiplier/accumulator, square root and divider.
// ----------------------------------------------------------------------------
module rtmd_datapath #(
    parameter int MAX_POINTS = rtmd_pkg::MAX_POINTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_valid,
    input  logic [rtmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rtmd_pkg::COORD_W-1:0]     cfg_data,
    input  logic [rtmd_pkg::TDATA_W-1:0]     s_tdata,
    input  logic                             s_tlast,
    input  logic                             m_tready,
    input  rtmd_pkg::cmd_t                   cmd,
    output rtmd_pkg::stat_t                  stat,
    output logic                             m_tvalid,
    output logic [rtmd_pkg::OUT_W-1:0]       m_tdata
);
    import rtmd_pkg::*;

    localparam int CNT_W = $clog2(MAX_POINTS + 1);

    logic signed [COORD_W-1:0] shift_reg [3];
    logic signed [ANGLE_W-1:0] tilt_reg [3];
    logic signed [COORD_W-1:0] fix_reg [3];
    logic signed [COORD_W:0]   mov_reg [3];
    logic                      last_reg;
    logic signed [CORD_W-1:0]  x_reg, y_reg;
    logic signed [ZW-1:0]      z_reg;
    logic                      flip_reg;
    logic signed [ENT_W-1:0]   sin_reg [3];
    logic signed [ENT_W-1:0]   cos_reg [3];
    logic signed [ENT_W-1:0]   t_reg [9];
    logic signed [ENT_W-1:0]   rot_reg [9];
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [ACC_W-1:0]   acc_reg;
    logic signed [OPB_W-1:0]   d_reg;
    logic [SQ_W-1:0]           sq_reg, v_reg, res_reg, bit_reg;
    logic [SUM_W-1:0]          sum_reg, dq_reg;
    logic [CNT_W-1:0]          count_reg, rem_reg;
    logic                      m_tvalid_reg;
    logic [OUT_W-1:0]          m_tdata_reg;

    logic signed [ZW-1:0]      ang;
    logic [4:0]                sh;
    logic signed [CORD_W-1:0]  xs, ys, xr, yr;
    logic signed [ZW-1:0]      at;
    logic [3:0]                ea, eb, es;
    logic signed [ENT_W-1:0]   a_op;
    logic signed [ENT_W-1:0]   b_full;
    logic signed [OPB_W-1:0]   b_op;
    logic signed [ACC_W-1:0]   acc_sum, rnd;
    logic signed [COORD_W-1:0] fix_sel;
    logic [SQ_W-1:0]           rb;
    logic [SUM_W:0]            sum_ext;
    logic [CNT_W:0]            tr;
    logic                      ge;

    always_comb begin
        case (cmd.axis)
            2'd0:    ang = {tilt_reg[0][ANGLE_W-1], tilt_reg[0]};
            2'd1:    ang = {tilt_reg[1][ANGLE_W-1], tilt_reg[1]};
            2'd2:    ang = {tilt_reg[2][ANGLE_W-1], tilt_reg[2]};
            default: ang = '0;
        endcase
        sh = cmd.step[4:0];
        xs = x_reg >>> sh;
        ys = y_reg >>> sh;
        at = $signed({3'b000, atan_deg(sh)});
        xr = (x_reg + 34'sd8192) >>> 14;
        yr = (y_reg + 34'sd8192) >>> 14;

        ea = 4'({2'b00, cmd.row} * 4'd3 + {2'b00, cmd.kk});
        eb = 4'({2'b00, cmd.kk} * 4'd3 + {2'b00, cmd.col});
        es = 4'({2'b00, cmd.row} * 4'd3 + {2'b00, cmd.col});

        a_op = '0;
        case (cmd.mode)
            MODE_T: begin
                case (ea)
                    4'd0, 4'd8: a_op = cos_reg[1];
                    4'd2:       a_op = -sin_reg[1];
                    4'd4:       a_op = ONE_Q16;
                    4'd6:       a_op = sin_reg[1];
                    default:    a_op = '0;
                endcase
            end
            MODE_R: begin
                case (ea)
                    4'd0, 4'd4: a_op = cos_reg[2];
                    4'd1:       a_op = sin_reg[2];
                    4'd3:       a_op = -sin_reg[2];
                    4'd8:       a_op = ONE_Q16;
                    default:    a_op = '0;
                endcase
            end
            MODE_P:  a_op = (ea <= 4'd8) ? rot_reg[ea] : '0;
            MODE_SQ: a_op = {{(ENT_W-OPB_W){d_reg[OPB_W-1]}}, d_reg};
            default: a_op = '0;
        endcase

        b_full = '0;
        case (cmd.mode)
            MODE_T: begin
                case (eb)
                    4'd0:       b_full = ONE_Q16;
                    4'd4, 4'd8: b_full = cos_reg[0];
                    4'd5:       b_full = sin_reg[0];
                    4'd7:       b_full = -sin_reg[0];
                    default:    b_full = '0;
                endcase
            end
            MODE_R: b_full = (eb <= 4'd8) ? t_reg[eb] : '0;
            MODE_P: begin
                case (cmd.kk)
                    2'd0:    b_full = {{(ENT_W-COORD_W-1){mov_reg[0][COORD_W]}}, mov_reg[0]};
                    2'd1:    b_full = {{(ENT_W-COORD_W-1){mov_reg[1][COORD_W]}}, mov_reg[1]};
                    2'd2:    b_full = {{(ENT_W-COORD_W-1){mov_reg[2][COORD_W]}}, mov_reg[2]};
                    default: b_full = '0;
                endcase
            end
            MODE_SQ: b_full = {{(ENT_W-OPB_W){d_reg[OPB_W-1]}}, d_reg};
            default: b_full = '0;
        endcase
        b_op = b_full[OPB_W-1:0];

        acc_sum = (cmd.acc_first ? '0 : acc_reg)
                + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        rnd = (acc_sum + 64'sd32768) >>> 16;
        case (cmd.row)
            2'd1:    fix_sel = fix_reg[1];
            2'd2:    fix_sel = fix_reg[2];
            default: fix_sel = fix_reg[0];
        endcase

        rb      = res_reg + bit_reg;
        sum_ext = {1'b0, sum_reg} + {{(SUM_W-30){1'b0}}, res_reg[30:0]};
        tr      = {rem_reg, dq_reg[SUM_W-1]};
        ge      = (tr >= {1'b0, count_reg});
    end

    // configuration and run-level control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                shift_reg[i] <= '0;
                tilt_reg[i]  <= '0;
            end
            sum_reg      <= '0;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    REG_SHIFT_X: shift_reg[0] <= cfg_data;
                    REG_SHIFT_Y: shift_reg[1] <= cfg_data;
                    REG_SHIFT_Z: shift_reg[2] <= cfg_data;
                    REG_TILT_X:  tilt_reg[0]  <= cfg_data[ANGLE_W-1:0];
                    REG_TILT_Y:  tilt_reg[1]  <= cfg_data[ANGLE_W-1:0];
                    REG_TILT_Z:  tilt_reg[2]  <= cfg_data[ANGLE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.sum_add) begin
                sum_reg   <= sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.out_load) begin
                sum_reg      <= '0;
                count_reg    <= '0;
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            for (int i = 0; i < 3; i++) begin
                fix_reg[i] <= s_tdata[COORD_W*i +: COORD_W];
                mov_reg[i] <= $signed({s_tdata[COORD_W*(i+3) + COORD_W-1],
                                       s_tdata[COORD_W*(i+3) +: COORD_W]})
                            + $signed({shift_reg[i][COORD_W-1], shift_reg[i]});
            end
            last_reg <= s_tlast;
        end
        if (cmd.cord_load) begin
            x_reg <= CORDIC_GAIN;
            y_reg <= '0;
            if (ang > DEG90) begin
                z_reg    <= ang - DEG180;
                flip_reg <= 1'b1;
            end else if (ang < -DEG90) begin
                z_reg    <= ang + DEG180;
                flip_reg <= 1'b1;
            end else begin
                z_reg    <= ang;
                flip_reg <= 1'b0;
            end
        end else if (cmd.cord_step) begin
            if (!z_reg[ZW-1]) begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - at;
            end else begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + at;
            end
        end
        if (cmd.cord_store && cmd.axis != 2'd3) begin
            cos_reg[cmd.axis] <= flip_reg ? -xr[ENT_W-1:0] : xr[ENT_W-1:0];
            sin_reg[cmd.axis] <= flip_reg ? -yr[ENT_W-1:0] : yr[ENT_W-1:0];
        end
        if (cmd.mul_en)  prod_reg <= a_op * b_op;
        if (cmd.acc_add) acc_reg  <= acc_sum;
        if (cmd.mac_store) begin
            case (cmd.mode)
                MODE_T:  if (es <= 4'd8) t_reg[es]   <= rnd[ENT_W-1:0];
                MODE_R:  if (es <= 4'd8) rot_reg[es] <= rnd[ENT_W-1:0];
                MODE_P:  d_reg <= {{(OPB_W-COORD_W){fix_sel[COORD_W-1]}}, fix_sel}
                                - rnd[OPB_W-1:0];
                default: ;
            endcase
        end
        if (cmd.sq_add) sq_reg <= (cmd.sq_first ? '0 : sq_reg) + prod_reg[SQ_W-1:0];
        if (cmd.sqrt_load) begin
            v_reg   <= sq_reg;
            res_reg <= '0;
            bit_reg <= SQ_W'(1) << (SQ_W - 2);
        end else if (cmd.sqrt_step) begin
            if (v_reg >= rb) begin
                v_reg   <= v_reg - rb;
                res_reg <= (res_reg >> 1) + bit_reg;
            end else begin
                res_reg <= res_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_load) begin
            rem_reg <= '0;
            dq_reg  <= sum_reg;
        end else if (cmd.div_step) begin
            rem_reg <= ge ? CNT_W'(tr - {1'b0, count_reg}) : tr[CNT_W-1:0];
            dq_reg  <= {dq_reg[SUM_W-2:0], ge};
        end
        if (cmd.out_load) begin
            m_tdata_reg <= (|dq_reg[SUM_W-1:OUT_W]) ? '1 : dq_reg[OUT_W-1:0];
        end
    end

    assign stat.cnt_zero = (count_reg == '0);
    assign stat.cnt_full = (count_reg == CNT_W'(MAX_POINTS));
    assign stat.last     = last_reg;
    assign stat.out_busy = m_tvalid_reg & ~m_tready;
    assign m_tvalid      = m_tvalid_reg;
    assign m_tdata       = m_tdata_reg;

endmodule

/* sv/rigid_transform_mean_distance.sv */
// ----------------------------------------------------------------------------
// rigid_transform_mean_distance
// Mean distance between fixed fiducials and rigidly transformed moving ones.
// ----------------------------------------------------------------------------
// One point is taken at a time. Each point runs three rows of
// multiply-accumulate steps plus a square-and-add on the one shared
// multiplier, then a bit-per-cycle square root. The first point of a
// run also builds the rotation: the three tilt angles on the shared CORDIC
// and then the matrix products. The point marked last adds a 40-step
// restoring division with its load and output states, and the result goes
// to an output register, so the next request is taken while the result waits.
module rigid_transform_mean_distance #(
    parameter int MAX_POINTS   = rtmd_pkg::MAX_POINTS_DEF,
    parameter int CORDIC_STEPS = rtmd_pkg::CORDIC_STEPS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rtmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [rtmd_pkg::COORD_W-1:0]   cfg_data,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // fixed_x, fixed_y, fixed_z, moving_x, moving_y, moving_z, 6 pad bits
    input  logic [rtmd_pkg::TDATA_W-1:0]   s_tdata,
    input  logic                           s_tlast,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // mean_distance
    output logic [rtmd_pkg::OUT_W-1:0]     m_tdata
);
    import rtmd_pkg::*;

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    rtmd_ctrl #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    rtmd_datapath #(
        .MAX_POINTS(MAX_POINTS)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tready  (m_tready),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata)
    );

endmodule

/* sv/rtmd_checker.sv */
// ----------------------------------------------------------------------------
// rtmd_checker
// Port-level checks of the mean distance block, bound to the top level.
// ----------------------------------------------------------------------------
module rtmd_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [rtmd_pkg::OUT_W-1:0]     m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy_after_req: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken without processing");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    a_cfg_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid |-> cfg_ready)
        else $error("configuration write stalled");

endmodule

bind rigid_transform_mean_distance rtmd_checker u_rtmd_checker (
    .aclk      (aclk),
    .aresetn   (aresetn),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
);
